// ===== src/bmf7_pkg.sv =====
// Shared constants, types and register codes for the 7x7 box mean filter.
package bmf7_pkg;

  // Frame limits and window geometry.
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;
  localparam int WIN        = 7;
  localparam int HALF       = 3;
  localparam int DIVISOR    = 49;

  // Field and counter widths.
  localparam int PIX_W  = 8;
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int WID_W  = COL_W + 1;
  localparam int HGT_W  = ROW_W + 1;
  localparam int TAPS   = WIN - 1;
  localparam int LINE_W = TAPS * PIX_W;
  localparam int CSUM_W = 11;
  localparam int WSUM_W = 14;

  // Division by 49 as a multiply by a rounded-up reciprocal; exact for 14-bit sums.
  localparam int DIV_SHIFT = 20;
  localparam int DIV_MUL   = ((1 << DIV_SHIFT) + DIVISOR - 1) / DIVISOR;
  localparam int MUL_W     = 15;
  localparam int PROD_W    = WSUM_W + MUL_W;

  // Configuration port.
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  typedef enum logic {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } reg_idx_t;

  // Clamped frame size handed from the register bank to the datapath.
  typedef struct packed {
    logic [WID_W-1:0] width;
    logic [HGT_W-1:0] height;
  } frame_size_t;

endpackage

// ===== src/box_mean_filter_7x7_core.sv =====
// Top level of the streaming 7x7 box mean filter.
//
//   channel  direction  handshake            payload
//   in       input      in_valid / in_stall   pixel, frame_start
//   out      output     out_valid / out_stall mean_value, out_row, out_col, last_of_frame
//   cfg      input      APB psel / penable    image_width, image_height
//
// One item is taken per clock cycle unless the input is stalled; the line store is read
// when an item is accepted and written back from the accumulate stage, with a same-column bypass.
// A result passes the accumulate, divide and output registers, the last after the divider.
// Reset clears the counters and the column sums; the line store is not cleared.
// The window sum is formed afresh from the seven column sums for every item.
// A stalled output holds its item; the divide and accumulate stages each take one more
// item, and only when both are full is the input stalled.
module box_mean_filter_7x7_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [bmf7_pkg::PIX_W-1:0]  pixel,
  input  logic                        frame_start,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [bmf7_pkg::PIX_W-1:0]  mean_value,
  output logic [bmf7_pkg::ROW_W-1:0]  out_row,
  output logic [bmf7_pkg::COL_W-1:0]  out_col,
  output logic                        last_of_frame,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bmf7_pkg::APB_AW-1:0] paddr,
  input  logic [bmf7_pkg::APB_DW-1:0] pwdata,
  output logic [bmf7_pkg::APB_DW-1:0] prdata,
  output logic                        pready
);
  import bmf7_pkg::*;

  frame_size_t size;

  // Position counters.
  logic [ROW_W-1:0] row_count, row_count_next;
  logic [COL_W-1:0] col_count, col_count_next;

  // Position of the arriving item.
  logic [HGT_W-1:0] r_base, r_step, r_pos, r_inc;
  logic [WID_W-1:0] c_base, c_pos, c_inc;
  logic             in_accept;
  logic             pos_emit, pos_last;

  // Accumulate stage.
  logic              p1_valid;
  logic [PIX_W-1:0]  p1_pixel;
  logic [COL_W-1:0]  p1_col;
  logic [ROW_W-1:0]  p1_row;
  logic              p1_emit, p1_last;
  logic              p1_go;
  logic [LINE_W-1:0] rd_data, wr_data;
  logic [CSUM_W-1:0] csum;
  logic [CSUM_W-1:0] column_sums [WIN];
  logic [WSUM_W-1:0] older_sum, window_sum_next;

  // Divide stage.
  logic              p2_valid;
  logic [WSUM_W-1:0] p2_sum;
  logic [ROW_W-1:0]  p2_row;
  logic [COL_W-1:0]  p2_col;
  logic              p2_last;
  logic              p2_free, o_free, o_load;
  logic [PROD_W-1:0] prod;

  bmf7_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .size    (size)
  );

  // Handshake across the three stages.
  assign o_free    = !out_valid || !out_stall;
  assign o_load    = p2_valid && o_free;
  assign p2_free   = !p2_valid || o_free;
  assign p1_go     = p1_valid && p2_free;
  assign in_stall  = p1_valid && !p2_free;
  assign in_accept = in_valid && !in_stall;

  // Column and row of the arriving pixel, wrapping past a shrunken frame size.
  always_comb begin
    if (frame_start) begin
      r_base = '0;
      c_base = '0;
    end else begin
      r_base = HGT_W'(row_count);
      c_base = WID_W'(col_count);
    end
    if (c_base >= size.width) begin
      c_pos  = '0;
      r_step = r_base + HGT_W'(1);
    end else begin
      c_pos  = c_base;
      r_step = r_base;
    end
    r_pos = (r_step >= size.height) ? '0 : r_step;
    c_inc = c_pos + WID_W'(1);
    r_inc = r_pos + HGT_W'(1);
    if (c_inc >= size.width) begin
      col_count_next = '0;
      row_count_next = (r_inc >= size.height) ? '0 : r_inc[ROW_W-1:0];
    end else begin
      col_count_next = c_inc[COL_W-1:0];
      row_count_next = r_pos[ROW_W-1:0];
    end
    pos_emit = (r_pos >= HGT_W'(WIN - 1)) && (c_pos >= WID_W'(WIN - 1));
    pos_last = (r_pos == size.height - HGT_W'(1)) && (c_pos == size.width - WID_W'(1));
  end

  // Counters advance on every accepted item.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= '0;
      col_count <= '0;
    end else if (in_accept) begin
      row_count <= row_count_next;
      col_count <= col_count_next;
    end
  end

  // Item registers for the accumulate stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else if (in_accept) begin
      p1_valid <= 1'b1;
    end else if (p1_go) begin
      p1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      p1_pixel <= pixel;
      p1_col   <= c_pos[COL_W-1:0];
      p1_row   <= r_pos[ROW_W-1:0] - ROW_W'(HALF);
      p1_emit  <= pos_emit;
      p1_last  <= pos_last;
    end
  end

  bmf7_line_ram u_line_ram (
    .clk     (clk),
    .rd_en   (in_accept),
    .rd_addr (c_pos[COL_W-1:0]),
    .rd_data (rd_data),
    .wr_en   (p1_go),
    .wr_addr (p1_col),
    .wr_data (wr_data)
  );

  // Column sum of the six stored pixels and the new one; the oldest pixel drops out.
  // The window sum adds the new column sum to the six newest held ones.
  always_comb begin
    csum = CSUM_W'(p1_pixel);
    for (int k = 0; k < TAPS; k++) begin
      csum = csum + CSUM_W'(rd_data[k*PIX_W +: PIX_W]);
    end
    wr_data   = {p1_pixel, rd_data[LINE_W-1:PIX_W]};
    older_sum = '0;
    for (int k = 0; k < WIN - 1; k++) begin
      older_sum = older_sum + WSUM_W'(column_sums[k]);
    end
    window_sum_next = older_sum + WSUM_W'(csum);
  end

  // Column sums of the last seven columns, newest first.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < WIN; k++) begin
        column_sums[k] <= '0;
      end
    end else if (p1_go) begin
      column_sums[0] <= csum;
      for (int k = 1; k < WIN; k++) begin
        column_sums[k] <= column_sums[k-1];
      end
    end
  end

  // Divide stage holds only items that give a result.
  always_ff @(posedge clk) begin
    if (rst) begin
      p2_valid <= 1'b0;
    end else if (p1_go && p1_emit) begin
      p2_valid <= 1'b1;
    end else if (o_load) begin
      p2_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (p1_go && p1_emit) begin
      p2_sum  <= window_sum_next;
      p2_row  <= p1_row;
      p2_col  <= p1_col - COL_W'(HALF);
      p2_last <= p1_last;
    end
  end

  // Division by 49 through the reciprocal multiply.
  assign prod = PROD_W'(p2_sum) * PROD_W'(DIV_MUL);

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (o_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (o_load) begin
      mean_value    <= prod[DIV_SHIFT +: PIX_W];
      out_row       <= p2_row;
      out_col       <= p2_col;
      last_of_frame <= p2_last;
    end
  end

endmodule

// ===== src/bmf7_regs.sv =====
// Configuration register bank with APB-style access and size clamping.
module bmf7_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bmf7_pkg::APB_AW-1:0] paddr,
  input  logic [bmf7_pkg::APB_DW-1:0] pwdata,
  output logic [bmf7_pkg::APB_DW-1:0] prdata,
  output logic                        pready,
  output bmf7_pkg::frame_size_t       size
);
  import bmf7_pkg::*;

  logic [WID_W-1:0] image_width;
  logic [HGT_W-1:0] image_height;
  logic             wr_en;
  reg_idx_t         idx;

  assign idx    = reg_idx_t'(paddr[2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  // Register writes complete in the access phase.
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WID_W'(512);
      image_height <= HGT_W'(512);
    end else if (wr_en) begin
      unique case (idx)
        REG_WIDTH:  image_width  <= pwdata[WID_W-1:0];
        REG_HEIGHT: image_height <= pwdata[HGT_W-1:0];
        default:    ;
      endcase
    end
  end

  // Read data follows the address.
  always_comb begin
    unique case (idx)
      REG_WIDTH:  prdata = APB_DW'(image_width);
      REG_HEIGHT: prdata = APB_DW'(image_height);
      default:    prdata = '0;
    endcase
  end

  // Effective frame size, held within the window and the storage limits.
  always_comb begin
    if (image_width < WID_W'(WIN)) begin
      size.width = WID_W'(WIN);
    end else if (image_width > WID_W'(MAX_WIDTH)) begin
      size.width = WID_W'(MAX_WIDTH);
    end else begin
      size.width = image_width;
    end
    if (image_height < HGT_W'(WIN)) begin
      size.height = HGT_W'(WIN);
    end else if (image_height > HGT_W'(MAX_HEIGHT)) begin
      size.height = HGT_W'(MAX_HEIGHT);
    end else begin
      size.height = image_height;
    end
  end

endmodule

// ===== src/bmf7_line_ram.sv =====
// Line store: one entry per column holding the six previous pixels of that column.
module bmf7_line_ram (
  input  logic                        clk,
  input  logic                        rd_en,
  input  logic [bmf7_pkg::COL_W-1:0]  rd_addr,
  output logic [bmf7_pkg::LINE_W-1:0] rd_data,
  input  logic                        wr_en,
  input  logic [bmf7_pkg::COL_W-1:0]  wr_addr,
  input  logic [bmf7_pkg::LINE_W-1:0] wr_data
);
  import bmf7_pkg::*;

  logic [LINE_W-1:0] mem [MAX_WIDTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read; a write to the same column in the same cycle is passed straight through.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data <= wr_data;
      end else begin
        rd_data <= mem[rd_addr];
      end
    end
  end

endmodule

// ===== src/bmf7_checker.sv =====
// Port-level checks for the box mean filter, bound to the top level.
module bmf7_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic [bmf7_pkg::PIX_W-1:0]  pixel,
  input logic                        frame_start,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [bmf7_pkg::PIX_W-1:0]  mean_value,
  input logic [bmf7_pkg::ROW_W-1:0]  out_row,
  input logic [bmf7_pkg::COL_W-1:0]  out_col,
  input logic                        last_of_frame,
  input logic                        psel,
  input logic                        penable,
  input logic                        pwrite,
  input logic [bmf7_pkg::APB_AW-1:0] paddr,
  input logic [bmf7_pkg::APB_DW-1:0] pwdata,
  input logic [bmf7_pkg::APB_DW-1:0] prdata,
  input logic                        pready
);
  import bmf7_pkg::*;

  // A stalled input item stays in place unchanged.
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid && $stable(pixel) && $stable(frame_start))
    else $error("input item changed while stalled");

  // A stalled result item stays in place unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(mean_value) && $stable(out_row)
      && $stable(out_col) && $stable(last_of_frame))
    else $error("result item changed while stalled");

  // Window centres lie at least three pixels from the top, the left and the widest frame's right edge.
  a_centre_inside: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_row >= ROW_W'(HALF) && out_col >= COL_W'(HALF)
      && out_col <= COL_W'(MAX_WIDTH - 1 - HALF))
    else $error("result centre too close to the frame edge");

  // The input is only held back when the output side is full and stalled.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while the output can move");

  // A width write reads back on the next cycle.
  a_width_readback: assert property (@(posedge clk) disable iff (rst)
    psel && penable && pwrite && pready && paddr == APB_AW'(0)
      |=> (paddr != APB_AW'(0) || prdata[WID_W-1:0] == $past(pwdata[WID_W-1:0])))
    else $error("width register does not read back the written value");

endmodule

bind box_mean_filter_7x7_core bmf7_checker u_bmf7_checker (.*);
